[sv/lcb_pkg.sv]
// ----------------------------------------------------------------------------
// lcb_pkg
// Shared sizes, command codes, beat types and helpers for the character
// display buffer with cursor.
// ----------------------------------------------------------------------------
package lcb_pkg;

    // buffer geometry
    localparam int ROWS    = 2;
    localparam int COLUMNS = 16;
    localparam int NCELLS  = ROWS * COLUMNS;

    // field and index widths
    localparam int ROW_W  = 1;
    localparam int COL_W  = 4;
    localparam int CHAR_W = 8;
    localparam int KIND_W = 4;
    localparam int CELL_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;

    // command codes
    typedef enum logic [KIND_W-1:0] {
        K_WRITE     = 4'd0,
        K_SET_CELL  = 4'd1,
        K_CLEAR     = 4'd2,
        K_CLEAR_EOL = 4'd3,
        K_UP        = 4'd4,
        K_DOWN      = 4'd5,
        K_LEFT      = 4'd6,
        K_RIGHT     = 4'd7,
        K_SET_CUR   = 4'd8
    } t_kind;

    // input beat
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ROW_W-1:0]  row_sel;
        logic [COL_W-1:0]  col_sel;
        logic [CHAR_W-1:0] char_code;
    } t_cmd;

    // output beat
    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CHAR_W-1:0] char_at_cursor;
    } t_rsp;

    // update request from the controller to the cell store
    typedef struct packed {
        logic              wr_en;
        logic [CELL_W-1:0] wr_addr;
        logic [CHAR_W-1:0] wr_data;
        logic              clr_all;
        logic              clr_eol;
        logic [ROW_W-1:0]  clr_row;
        logic [COL_W-1:0]  clr_col;
    } t_store_req;

    // linear cell address of a row and column
    function automatic logic [CELL_W-1:0] cell_idx(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
        logic [CELL_W+COL_W:0] prod;
        prod = (CELL_W+COL_W+1)'(r) * (CELL_W+COL_W+1)'(COLUMNS)
             + (CELL_W+COL_W+1)'(c);
        return prod[CELL_W-1:0];
    endfunction

endpackage

[sv/char_lcd_buffer_cursor.sv]
// ----------------------------------------------------------------------------
// char_lcd_buffer_cursor
// 2 x 16 character display buffer with a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one command
//   beat: write and advance, set cell, clear, clear to end of line, cursor
//   up/down/left/right, or set cursor. Output channel (o_out_valid /
//   i_out_stall / o_out_data) returns one beat per command with the cursor
//   position and the character stored under it.
//   A command's result is loaded into the output register as follows: the
//   update goes to the cell memory at accept, then the cell under the new
//   cursor is read through the memory's registered read port (S_READ), and
//   the read data is captured with the cursor in S_CAP.
//   No new command is taken until the last one is done; clears are done
//   through per-cell valid flags, so every command costs the same.
//   Reset clears the cursor, all cell valid flags (every cell reads blank)
//   and the output valid flag; a command can be taken the cycle after reset.
//   When the receiver stalls, the result holds in the output register and
//   one more command may be accepted and processed; it then waits for the
//   output register to free up before input is taken again.
// ----------------------------------------------------------------------------
module char_lcd_buffer_cursor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lcb_pkg::t_cmd i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lcb_pkg::t_rsp o_out_data
);
    import lcb_pkg::*;

    t_store_req        req;
    logic              rd_en;
    logic [CELL_W-1:0] rd_addr;
    logic [CHAR_W-1:0] rd_data;

    // command decode, cursor and result register
    lcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_req       (req),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    // character memory
    lcb_cell_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

[sv/lcb_cell_store.sv]
// ----------------------------------------------------------------------------
// lcb_cell_store
// Character memory with one write and one registered read port. A valid
// flag per cell marks cells written since the last clear; a cell without
// its flag reads as blank.
// ----------------------------------------------------------------------------
module lcb_cell_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lcb_pkg::t_store_req       i_req,
    input  logic                      i_rd_en,
    input  logic [lcb_pkg::CELL_W-1:0] i_rd_addr,
    output logic [lcb_pkg::CHAR_W-1:0] o_rd_data
);
    import lcb_pkg::*;

    logic [CHAR_W-1:0] r_mem [NCELLS];
    logic [NCELLS-1:0] r_valid;
    logic [CHAR_W-1:0] r_rd_data;
    logic              r_rd_ok;

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_ok   <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

    // per-cell valid flags: set on write, dropped by clears
    for (genvar g = 0; g < NCELLS; g++) begin : g_valid
        localparam int GROW = g / COLUMNS;
        localparam int GCOL = g % COLUMNS;
        logic in_eol;
        assign in_eol = i_req.clr_eol
                      && (int'(i_req.clr_row) == GROW)
                      && (GCOL >= int'(i_req.clr_col));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_req.clr_all || in_eol) begin
                r_valid[g] <= 1'b0;
            end else if (i_req.wr_en && (i_req.wr_addr == CELL_W'(g))) begin
                r_valid[g] <= 1'b1;
            end
        end
    end

endmodule

[sv/lcb_ctrl.sv]
// ----------------------------------------------------------------------------
// lcb_ctrl
// Command decoder, cursor registers and output register. Issues the cell
// update on accept, then reads the cell under the new cursor.
// ----------------------------------------------------------------------------
module lcb_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  lcb_pkg::t_cmd              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output lcb_pkg::t_rsp              o_out_data,
    output lcb_pkg::t_store_req        o_req,
    output logic                       o_rd_en,
    output logic [lcb_pkg::CELL_W-1:0] o_rd_addr,
    input  logic [lcb_pkg::CHAR_W-1:0] i_rd_data
);
    import lcb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CAP
    } t_state;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    t_state           r_state;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_out_valid;
    t_rsp             r_out_data;

    logic             accept;
    logic             target_ok;
    logic [ROW_W-1:0] rt_row, lf_row;
    logic [COL_W-1:0] rt_col, lf_col;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign target_ok = (int'(i_in_data.row_sel) < ROWS)
                    && (int'(i_in_data.col_sel) < COLUMNS);

    // right and left neighbors with row wrap, stopping at the ends
    always_comb begin
        rt_row = r_row;
        rt_col = r_col;
        if (r_col == LAST_COL) begin
            if (r_row < LAST_ROW) begin
                rt_row = r_row + ROW_W'(1);
                rt_col = '0;
            end
        end else begin
            rt_col = r_col + COL_W'(1);
        end
        lf_row = r_row;
        lf_col = r_col;
        if (r_col == '0) begin
            if (r_row != '0) begin
                lf_row = r_row - ROW_W'(1);
                lf_col = LAST_COL;
            end
        end else begin
            lf_col = r_col - COL_W'(1);
        end
    end

    // command decode: next cursor and cell update
    always_comb begin
        n_row         = r_row;
        n_col         = r_col;
        o_req         = '0;
        o_req.wr_addr = cell_idx(r_row, r_col);
        o_req.wr_data = i_in_data.char_code;
        o_req.clr_row = r_row;
        o_req.clr_col = r_col;
        case (i_in_data.kind)
            K_WRITE: begin
                o_req.wr_en = accept;
                n_row       = rt_row;
                n_col       = rt_col;
            end
            K_SET_CELL: begin
                o_req.wr_en   = accept && target_ok;
                o_req.wr_addr = cell_idx(i_in_data.row_sel, i_in_data.col_sel);
            end
            K_CLEAR: begin
                o_req.clr_all = accept;
            end
            K_CLEAR_EOL: begin
                o_req.clr_eol = accept;
            end
            K_UP: begin
                if (r_row != '0) n_row = r_row - ROW_W'(1);
            end
            K_DOWN: begin
                if (r_row < LAST_ROW) n_row = r_row + ROW_W'(1);
            end
            K_LEFT: begin
                n_row = lf_row;
                n_col = lf_col;
            end
            K_RIGHT: begin
                n_row = rt_row;
                n_col = rt_col;
            end
            K_SET_CUR: begin
                if (target_ok) begin
                    n_row = i_in_data.row_sel;
                    n_col = i_in_data.col_sel;
                end
            end
            default: begin
            end
        endcase
    end

    // read of the cell under the cursor
    assign o_rd_en   = (r_state == S_READ);
    assign o_rd_addr = cell_idx(r_row, r_col);

    // sequencer, cursor and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result valid: load from the read, or drop once taken
            if ((r_state == S_CAP) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_row   <= n_row;
                        r_col   <= n_col;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_data.cursor_row     <= r_row;
                        r_out_data.cursor_col     <= r_col;
                        r_out_data.char_at_cursor <= i_rd_data;
                        r_state                   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[sv/lcb_checker.sv]
// ----------------------------------------------------------------------------
// lcb_checker
// Port-level checks for the character display buffer, bound to the top.
// ----------------------------------------------------------------------------
module lcb_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input lcb_pkg::t_cmd i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input lcb_pkg::t_rsp o_out_data
);
    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // no result beat right after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

    // ready for a command right after reset
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // one command in work at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("second command taken while busy");

    // a fresh result beat is checked against an earlier accepted command
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_acc, 3))
        else $error("result beat without matching command");

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

endmodule

bind char_lcd_buffer_cursor lcb_checker u_lcb_checker (.*);
